[design/kyc_pkg.sv]
// Shared types and constants for the Knuth-Yao cached matrix sampler.
package kyc_pkg;

   localparam int MAX_OUTCOMES = 64;
   localparam int MAX_COLUMNS  = 32;

   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int ROW_W      = $clog2(MAX_OUTCOMES);
   localparam int ROW_ADDR_W = ROW_W + COL_W;
   localparam int CNT_W      = 7;
   localparam int OFF_W      = 8;
   localparam int OUT_W      = 7;

   // input item opcodes
   typedef enum logic [1:0] {
      OP_BIT      = 2'd0,
      OP_WR_COUNT = 2'd1,
      OP_WR_ROW   = 2'd2
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_NUM_OUTCOMES = 2'd0,
      REG_NUM_COLUMNS  = 2'd1,
      REG_LOOP_COLUMN  = 2'd2,
      REG_REJECT_MODE  = 2'd3
   } reg_type;

   typedef struct packed {
      logic [6:0] num_outcomes;
      logic [5:0] num_columns;
      logic [4:0] loop_column;
      logic       reject_mode;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic cnt_wr;
      logic row_wr;
      logic cnt_rd;
      logic row_rd;
      logic walk_restart;
      logic walk_advance;
      logic emit_one;
      logic emit_row;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single;
      logic hit;
      logic at_last;
      logic reject_mode;
      logic row_reject;
      logic out_free;
   } status_type;

endpackage

[design/knuth_yao_cached_matrix_sampler.sv]
// Top level of the Knuth-Yao tree-walk sampler with cached leaf tables.
// Bit items: accept, then count read; when a leaf is hit a dependent row-table read follows.
// A result comes from the count step in single-outcome plain mode, else from the row step.
// Table-write items complete in the accept step. No new item is taken until the count then
// row read chain is done; a result waits in place while the output register is stalled.
// Reset (sync, active high) clears the walk, empties the output, loads register defaults.
module knuth_yao_cached_matrix_sampler
   import kyc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // random_bit[0], column[5:1], leaf_index[11:6],
                                    // value[18:12], zero pad[23:19]
   input  logic [1:0]  req_tuser,   // op[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // outcome[6:0], zero pad[7]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type          cfg_ff;
   cmd_type          cmd;
   status_type       status;
   logic             csr_wr;
   logic [1:0]       reg_idx;
   logic [OUT_W-1:0] outcome;

   // ---------------------------------------------------------------
   // Registers: one word per register, written on the access phase.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_outcomes <= 7'd1;
         cfg_ff.num_columns  <= 6'd1;
         cfg_ff.loop_column  <= '0;
         cfg_ff.reject_mode  <= 1'b0;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_NUM_OUTCOMES: cfg_ff.num_outcomes <= csr_pwdata[6:0];
            REG_NUM_COLUMNS:  cfg_ff.num_columns  <= csr_pwdata[5:0];
            REG_LOOP_COLUMN:  cfg_ff.loop_column  <= csr_pwdata[4:0];
            REG_REJECT_MODE:  cfg_ff.reject_mode  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_NUM_OUTCOMES: csr_prdata = {25'd0, cfg_ff.num_outcomes};
         REG_NUM_COLUMNS:  csr_prdata = {26'd0, cfg_ff.num_columns};
         REG_LOOP_COLUMN:  csr_prdata = {27'd0, cfg_ff.loop_column};
         REG_REJECT_MODE:  csr_prdata = {31'd0, cfg_ff.reject_mode};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Controller: takes an item only when idle; a bit item walks
   // through the count read and, on a leaf hit, the row read.
   // ---------------------------------------------------------------
   kyc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .op        (req_tuser),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // ---------------------------------------------------------------
   // Datapath: tables, walk column/offset and the output register,
   // which lets the next item in while a result waits.
   // ---------------------------------------------------------------
   kyc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .random_bit (req_tdata[0]),
      .column     (req_tdata[5:1]),
      .leaf_index (req_tdata[11:6]),
      .value      (req_tdata[18:12]),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .outcome    (outcome)
   );

   assign rsp_tdata = {1'b0, outcome};

endmodule

[design/kyc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kyc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/kyc_ctrl.sv]
// Control state machine for the tree walk: sequences table reads and emits.
module kyc_ctrl
   import kyc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] op,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_ROW
   } state_type;

   state_type state_ff, state_in;
   logic      fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign fire      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               case (op)
                  OP_BIT: begin
                     cmd.cnt_rd = 1'b1;
                     state_in   = ST_COUNT;
                  end
                  OP_WR_COUNT: cmd.cnt_wr = 1'b1;
                  OP_WR_ROW:   cmd.row_wr = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_COUNT: begin
            if (status.single) begin
               // single-outcome plain mode: answer 1, wait for output slot
               if (status.out_free) begin
                  cmd.emit_one     = 1'b1;
                  cmd.walk_restart = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else if (status.hit) begin
               cmd.row_rd = 1'b1;
               state_in   = ST_ROW;
            end else if (status.at_last && status.reject_mode) begin
               cmd.walk_restart = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.walk_advance = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_ROW: begin
            if (status.row_reject) begin
               cmd.walk_restart = 1'b1;
               state_in         = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_row     = 1'b1;
               cmd.walk_restart = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/kyc_datapath.sv]
// Walk state, count and row tables, step arithmetic and output register.
module kyc_datapath
   import kyc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  cmd_type          cmd,
   input  logic             random_bit,
   input  logic [4:0]       column,
   input  logic [5:0]       leaf_index,
   input  logic [6:0]       value,
   output status_type       status,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [OUT_W-1:0] outcome
);

   logic [COL_W-1:0]      walk_col_ff;
   logic [OFF_W-1:0]      walk_off_ff;
   logic                  bit_ff;
   logic                  rsp_valid_ff;
   logic [OUT_W-1:0]      outcome_ff;

   logic [CNT_W-1:0]      count_rd;
   logic [ROW_W-1:0]      row_rd;
   logic                  col_ok;
   logic                  leaf_ok;
   logic [ROW_ADDR_W-1:0] row_wr_addr;
   logic [ROW_ADDR_W-1:0] row_rd_addr;

   logic [OFF_W:0]        depth;
   logic [OFF_W:0]        diff;
   logic [5:0]            cols_minus_one;
   logic [COL_W-1:0]      last_col;
   logic [COL_W-1:0]      next_col;
   logic [OUT_W-1:0]      row_plus_one;

   // table writes out of range are dropped
   assign col_ok      = int'(column) < MAX_COLUMNS;
   assign leaf_ok     = int'(leaf_index) < MAX_OUTCOMES;
   assign row_wr_addr = {leaf_index[ROW_W-1:0], column[COL_W-1:0]};

   kyc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cmd.cnt_wr && col_ok),
      .wr_addr (column[COL_W-1:0]),
      .wr_data (value),
      .rd_en   (cmd.cnt_rd),
      .rd_addr (walk_col_ff),
      .rd_data (count_rd)
   );

   kyc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_OUTCOMES * MAX_COLUMNS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.row_wr && col_ok && leaf_ok),
      .wr_addr (row_wr_addr),
      .wr_data (value[ROW_W-1:0]),
      .rd_en   (cmd.row_rd),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd)
   );

   // next tree level: double offset, add inverted bit
   assign depth       = {walk_off_ff, 1'b0} + {{OFF_W{1'b0}}, ~bit_ff};
   assign diff        = depth - (OFF_W+1)'(count_rd);
   assign row_rd_addr = {depth[ROW_W-1:0], walk_col_ff};

   assign cols_minus_one = cfg.num_columns - 6'd1;
   always_comb begin
      if (cfg.num_columns == '0 || int'(cfg.num_columns) > MAX_COLUMNS) begin
         last_col = COL_W'(MAX_COLUMNS - 1);
      end else begin
         last_col = cols_minus_one[COL_W-1:0];
      end
   end

   always_comb begin
      if (walk_col_ff >= last_col) begin
         next_col = (cfg.loop_column <= last_col) ? cfg.loop_column : '0;
      end else begin
         next_col = walk_col_ff + COL_W'(1);
      end
   end

   assign row_plus_one = OUT_W'(row_rd) + OUT_W'(1);

   assign status.single      = !cfg.reject_mode && (cfg.num_outcomes == OUT_W'(1));
   assign status.hit         = depth < (OFF_W+1)'(count_rd);
   assign status.at_last     = walk_col_ff >= last_col;
   assign status.reject_mode = cfg.reject_mode;
   assign status.row_reject  = cfg.reject_mode && (row_plus_one >= cfg.num_outcomes);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_col_ff  <= '0;
         walk_off_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.walk_restart) begin
            walk_col_ff <= '0;
            walk_off_ff <= '0;
         end else if (cmd.walk_advance) begin
            walk_col_ff <= next_col;
            walk_off_ff <= diff[OFF_W-1:0];
         end
         if (cmd.emit_one || cmd.emit_row) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_rd) begin
         bit_ff <= random_bit;
      end
      if (cmd.emit_one) begin
         outcome_ff <= OUT_W'(1);
      end else if (cmd.emit_row) begin
         outcome_ff <= row_plus_one;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign outcome   = outcome_ff;

endmodule

[design/kyc_checker.sv]
// Port-level assertions for the sampler, bound to the top level.
module kyc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a waiting result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // outcomes are one-based and fit seven bits
   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] != 7'd0) && !rsp_tdata[7])
      else $error("outcome out of range");

   // a result never appears the cycle after an item was taken
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result without a table read");

endmodule

bind knuth_yao_cached_matrix_sampler kyc_checker u_kyc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
